// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands. They expect clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define FCCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define FCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fccw_pkg.sv -----
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types, codes and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fccw_pkg;

  // Field widths
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 13;
  localparam int BYTE_W      = 8;
  localparam int CLUSTER_W   = 12;
  localparam int SIZE_W      = 24;
  localparam int STATUS_W    = 3;
  localparam int CYL_W       = 8;
  localparam int SECTOR_W    = 5;
  localparam int CHUNK_OUT_W = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DAS_W       = 16;
  localparam int SPC_W       = 8;

  // Datapath widths
  localparam int PROD_W  = CLUSTER_W + SPC_W;   // (cluster - 2) * spc
  localparam int LBA_W   = PROD_W + 1;          // plus data area start
  localparam int RECIP_W = 21;
  localparam int DIVP_W  = LBA_W - 1 + RECIP_W; // (lba >> 1) * reciprocal of 9
  localparam int QUOT_W  = DIVP_W - 24;

  // lba / 18 == (lba >> 1) / 9, exact for 20-bit operands
  localparam logic [RECIP_W-1:0] DIV9_MULT  = 21'd1864136;
  localparam int                 DIV9_SHIFT = 24;

  localparam logic [CLUSTER_W-1:0] CLUSTER_MIN       = 12'h002;
  localparam logic [CLUSTER_W-1:0] CLUSTER_MAX       = 12'hFF6;
  localparam logic [SECTOR_W-1:0]  SECTORS_PER_TRACK = 5'd18;

  localparam logic [DAS_W-1:0] DATA_AREA_RESET = 16'd33;
  localparam logic [SPC_W-1:0] SPC_RESET       = 8'd1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_AREA_START     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_CLUSTER = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED    = 3'd0,
    STAT_STARTED   = 3'd1,
    STAT_SECTOR    = 3'd2,
    STAT_COMPLETE  = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_TOO_LARGE = 3'd5
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture accepted word
    logic stage_lo;   // low table byte + cluster product, address high byte
    logic stage_hi;   // high table byte + LBA sum
    logic stage_div;  // quotient by 18
    logic finish;     // update walk state and result register
  } ctrl_cmd_t;

  function automatic logic in_chain(input logic [CLUSTER_W-1:0] c);
    return (c >= CLUSTER_MIN) && (c <= CLUSTER_MAX);
  endfunction

endpackage

`default_nettype wire

// ----- sv/fccw_intf.sv -----
// ----------------------------------------------------------------------------
// fccw_intf
// Valid/ready channel interfaces: item input, result output, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fccw_item_if;
  import fccw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [INDEX_W-1:0]   table_index;
  logic [BYTE_W-1:0]    table_byte;
  logic [CLUSTER_W-1:0] start_cluster;
  logic [SIZE_W-1:0]    file_length;
  logic [SIZE_W-1:0]    dest_limit;

  modport source (output valid, operation, table_index, table_byte, start_cluster,
                  file_length, dest_limit, input ready);
  modport sink   (input valid, operation, table_index, table_byte, start_cluster,
                  file_length, dest_limit, output ready);
endinterface

interface fccw_result_if;
  import fccw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [CYL_W-1:0]       cylinder;
  logic                   head;
  logic [SECTOR_W-1:0]    sector_number;
  logic [CHUNK_OUT_W-1:0] chunk_bytes;
  logic [SIZE_W-1:0]      dest_offset;
  logic                   last;

  modport source (output valid, status, cylinder, head, sector_number, chunk_bytes,
                  dest_offset, last, input ready);
  modport sink   (input valid, status, cylinder, head, sector_number, chunk_bytes,
                  dest_offset, last, output ready);
endinterface

interface fccw_cfg_if;
  import fccw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/fccw_ram.sv -----
// ----------------------------------------------------------------------------
// fccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/fccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// fccw_ctrl
// Sequencer: accepts one word, steps the datapath, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fccw_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic [fccw_pkg::OP_W-1:0] item_op,
  output logic                     item_ready,
  output logic                     result_valid,
  input  logic                     result_ready,
  output fccw_pkg::ctrl_cmd_t      cmd
);
  import fccw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  op_t    op_in;
  logic   accept;
  logic   slot_free;

  assign op_in      = op_t'(item_op);
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.stage_lo  = (state == S_LO);
    cmd.stage_hi  = (state == S_HI);
    cmd.stage_div = (state == S_DIV);
    cmd.finish    = (state == S_FIN) && slot_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op_in == OP_NEXT) begin
              state <= S_LO;
            end else if (op_in inside {OP_WRITE, OP_START}) begin
              state <= S_FIN;
            end else begin
              state <= S_IDLE;  // unused code: dropped
            end
          end
        end
        S_LO:  state <= S_HI;
        S_HI:  state <= S_DIV;
        S_DIV: state <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/fccw_datapath.sv -----
// ----------------------------------------------------------------------------
// fccw_datapath
// Table memory, walk state, LBA and CHS arithmetic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fccw_datapath #(
  parameter int FAT_BYTES    = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fccw_pkg::ctrl_cmd_t               cmd,
  // accepted word
  input  logic [fccw_pkg::OP_W-1:0]         operation,
  input  logic [fccw_pkg::INDEX_W-1:0]      table_index,
  input  logic [fccw_pkg::BYTE_W-1:0]       table_byte,
  input  logic [fccw_pkg::CLUSTER_W-1:0]    start_cluster,
  input  logic [fccw_pkg::SIZE_W-1:0]       file_length,
  input  logic [fccw_pkg::SIZE_W-1:0]       dest_limit,
  // config writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fccw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fccw_pkg::CFG_DATA_W-1:0]   cfg_data,
  // result payload
  output logic [fccw_pkg::STATUS_W-1:0]     status,
  output logic [fccw_pkg::CYL_W-1:0]        cylinder,
  output logic                              head,
  output logic [fccw_pkg::SECTOR_W-1:0]     sector_number,
  output logic [fccw_pkg::CHUNK_OUT_W-1:0]  chunk_bytes,
  output logic [fccw_pkg::SIZE_W-1:0]       dest_offset,
  output logic                              last
);
  import fccw_pkg::*;

  localparam int AW = $clog2(FAT_BYTES);
  localparam int CW = $clog2(SECTOR_BYTES + 1);

  // held word
  op_t                  op_q;
  logic [INDEX_W-1:0]   tidx_q;
  logic [BYTE_W-1:0]    tbyte_q;
  logic [CLUSTER_W-1:0] first_q;
  logic [SIZE_W-1:0]    flen_q;
  logic [SIZE_W-1:0]    dlim_q;

  // config and walk state
  logic [DAS_W-1:0]     das;
  logic [SPC_W-1:0]     spc;
  logic [CLUSTER_W-1:0] cur;
  logic [SIZE_W-1:0]    bytes_done;
  logic [SIZE_W-1:0]    file_total;
  logic                 walk_active;

  // step registers
  logic [BYTE_W-1:0] lo_byte;
  logic [BYTE_W-1:0] hi_byte;
  logic [PROD_W-1:0] prod;
  logic [LBA_W-1:0]  lba;
  logic [QUOT_W-1:0] q18;

  // combinational
  logic [INDEX_W-1:0]   off;
  logic [INDEX_W-1:0]   off_hi;
  logic                 lo_ok;
  logic                 hi_ok;
  logic                 wr_ok;
  logic                 ram_we;
  logic [AW-1:0]        raddr;
  logic [BYTE_W-1:0]    rd_data;
  logic [DIVP_W-1:0]    div_prod;
  logic [LBA_W-1:0]     trk_base;
  logic [SECTOR_W-1:0]  sec_rem;
  logic [15:0]          entry;
  logic [CLUSTER_W-1:0] nxt;
  logic [SIZE_W-1:0]    remain;
  logic [CW-1:0]        chunk;
  logic [SIZE_W-1:0]    bd_next;
  logic                 fin;
  logic                 can_walk;

  assign cfg_ready = 1'b1;

  // capture accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(operation);
      tidx_q  <= table_index;
      tbyte_q <= table_byte;
      first_q <= start_cluster;
      flen_q  <= file_length;
      dlim_q  <= dest_limit;
    end
  end

  // packed entry sits at byte cluster * 1.5
  assign off    = INDEX_W'(cur) + INDEX_W'(cur >> 1);
  assign off_hi = off + INDEX_W'(1);
  assign lo_ok  = {1'b0, off} < (INDEX_W + 1)'(FAT_BYTES);
  assign hi_ok  = {1'b0, off_hi} < (INDEX_W + 1)'(FAT_BYTES);
  assign wr_ok  = {1'b0, tidx_q} < (INDEX_W + 1)'(FAT_BYTES);
  assign ram_we = cmd.finish && (op_q == OP_WRITE) && wr_ok;
  assign raddr  = cmd.stage_lo ? off_hi[AW-1:0] : off[AW-1:0];

  fccw_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FAT_BYTES)
  ) u_fat_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tidx_q[AW-1:0]),
    .wdata(tbyte_q),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // table bytes and LBA steps
  assign div_prod = DIVP_W'(lba[LBA_W-1:1]) * DIVP_W'(DIV9_MULT);

  always_ff @(posedge clk) begin
    if (cmd.stage_lo) begin
      lo_byte <= lo_ok ? rd_data : '0;
      prod    <= PROD_W'(cur - CLUSTER_MIN) * PROD_W'(spc);
    end
    if (cmd.stage_hi) begin
      hi_byte <= hi_ok ? rd_data : '0;
      lba     <= LBA_W'(das) + LBA_W'(prod);
    end
    if (cmd.stage_div) begin
      q18 <= div_prod[DIVP_W-1:DIV9_SHIFT];
    end
  end

  // sector within track and next cluster
  assign trk_base = LBA_W'(q18) * LBA_W'(SECTORS_PER_TRACK);
  assign sec_rem  = SECTOR_W'(lba - trk_base);
  assign entry    = {hi_byte, lo_byte};
  assign nxt      = cur[0] ? entry[15:4] : entry[11:0];

  // chunk and walk end
  assign remain   = file_total - bytes_done;
  assign chunk    = (remain < SIZE_W'(SECTOR_BYTES)) ? remain[CW-1:0] : CW'(SECTOR_BYTES);
  assign bd_next  = bytes_done + SIZE_W'(chunk);
  assign fin      = (bd_next >= file_total) || !in_chain(nxt);
  assign can_walk = walk_active && in_chain(cur) && (bytes_done < file_total);

  // config and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      das         <= DATA_AREA_RESET;
      spc         <= SPC_RESET;
      cur         <= '0;
      bytes_done  <= '0;
      file_total  <= '0;
      walk_active <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DATA_AREA_START:     das <= cfg_data[DAS_W-1:0];
          REG_SECTORS_PER_CLUSTER: spc <= cfg_data[SPC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        case (op_q)
          OP_START: begin
            if (first_q == '0 || flen_q > dlim_q) begin
              walk_active <= 1'b0;
            end else begin
              cur         <= first_q;
              bytes_done  <= '0;
              file_total  <= flen_q;
              walk_active <= 1'b1;
            end
          end
          OP_NEXT: begin
            if (can_walk) begin
              bytes_done <= bd_next;
              cur        <= nxt;
              if (fin) begin
                walk_active <= 1'b0;
              end
            end else begin
              walk_active <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cylinder      <= '0;
      head          <= 1'b0;
      sector_number <= '0;
      chunk_bytes   <= '0;
      dest_offset   <= '0;
      last          <= 1'b0;
      case (op_q)
        OP_WRITE: status <= STAT_STORED;
        OP_START: begin
          if (first_q == '0) begin
            status <= STAT_NOT_FOUND;
          end else if (flen_q > dlim_q) begin
            status <= STAT_TOO_LARGE;
          end else begin
            status <= STAT_STARTED;
          end
        end
        OP_NEXT: begin
          if (can_walk) begin
            status        <= STAT_SECTOR;
            cylinder      <= q18[CYL_W:1];
            head          <= q18[0];
            sector_number <= sec_rem + SECTOR_W'(1);
            chunk_bytes   <= CHUNK_OUT_W'(chunk);
            dest_offset   <= bytes_done;
            last          <= fin;
          end else begin
            status <= STAT_COMPLETE;
          end
        end
        default: status <= STAT_STORED;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/fat12_cluster_chain_walker_unit.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_unit
// FAT12 table store and cluster chain walker producing floppy CHS reads.
// ----------------------------------------------------------------------------
// The block takes one input word at a time. A table write or a file start
// steps from idle to the finish step, where its result word is registered,
// and the next word can be taken once the block is back in idle. A
// next-sector word steps through the low byte, high byte, divide and finish
// steps before its result is registered, as set by the two serial reads of
// the packed 12-bit entry through the single read port of the table RAM and
// by the registered multiply steps of the LBA and the divide by 18. A waiting
// result does not block acceptance of the next word; that word then holds in
// its last step until the result register is free. Config writes are taken
// at any time and must only be issued while the block is idle. The table RAM
// is not cleared at reset; entries read before being written are undefined.
`default_nettype none

module fat12_cluster_chain_walker_unit #(
  parameter int FAT_BYTES    = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  fccw_item_if.sink     item,
  fccw_result_if.source result,
  fccw_cfg_if.sink      cfg
);
  import fccw_pkg::*;

  ctrl_cmd_t cmd;

  fccw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_op     (item.operation),
    .item_ready  (item.ready),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .cmd         (cmd)
  );

  fccw_datapath #(
    .FAT_BYTES   (FAT_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (item.operation),
    .table_index  (item.table_index),
    .table_byte   (item.table_byte),
    .start_cluster(item.start_cluster),
    .file_length  (item.file_length),
    .dest_limit   (item.dest_limit),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .status       (result.status),
    .cylinder     (result.cylinder),
    .head         (result.head),
    .sector_number(result.sector_number),
    .chunk_bytes  (result.chunk_bytes),
    .dest_offset  (result.dest_offset),
    .last         (result.last)
  );

endmodule

`default_nettype wire

// ----- sv/fccw_checker.sv -----
// ----------------------------------------------------------------------------
// fccw_checker
// Port-level assertions for the cluster chain walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fccw_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic [fccw_pkg::OP_W-1:0]          item_operation,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [fccw_pkg::STATUS_W-1:0]      status,
  input logic [fccw_pkg::CYL_W-1:0]         cylinder,
  input logic                               head,
  input logic [fccw_pkg::SECTOR_W-1:0]      sector_number,
  input logic [fccw_pkg::CHUNK_OUT_W-1:0]   chunk_bytes,
  input logic [fccw_pkg::SIZE_W-1:0]        dest_offset,
  input logic                               last
);
  import fccw_pkg::*;

  // a pending result word stays until taken
  `FCCW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

  // one word in flight: busy right after taking a real operation
  `FCCW_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready && item_operation != OP_NONE, !item_ready, "second word taken while busy")

  // only sector words carry location data
  `FCCW_ASSERT_SAME(a_nonsector_zero, result_valid && status != STAT_SECTOR, cylinder == '0 && !head && sector_number == '0 && chunk_bytes == '0 && dest_offset == '0 && !last, "non-sector result has payload")

  // sector location and chunk are in range
  `FCCW_ASSERT_SAME(a_sector_range, result_valid && status == STAT_SECTOR, sector_number >= 5'd1 && sector_number <= SECTORS_PER_TRACK && chunk_bytes != '0, "sector result out of range")

endmodule

bind fat12_cluster_chain_walker_unit fccw_checker u_fccw_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .item_operation(item.operation),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .status        (result.status),
  .cylinder      (result.cylinder),
  .head          (result.head),
  .sector_number (result.sector_number),
  .chunk_bytes   (result.chunk_bytes),
  .dest_offset   (result.dest_offset),
  .last          (result.last)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FAT12 cluster chain walker. Builds cluster
// chains in the table one word at a time, walks them and compares every
// result word with a cycle-free model of the walk, under several settings of
// the data area start and cluster size and with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb;
  import fccw_pkg::*;

  localparam int          FAT_SIZE      = 8192;
  localparam int          SECTOR_SIZE   = 512;
  localparam logic [11:0] CHAIN_LO      = 12'h002;
  localparam logic [11:0] CHAIN_HI      = 12'hFF6;
  localparam int          TRACK_SECTORS = 18;
  localparam int          CYL_SECTORS   = 36;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SEG_ITEMS     = 128;

  typedef struct packed {
    op_t                  op;
    logic [INDEX_W-1:0]   tindex;
    logic [BYTE_W-1:0]    tbyte;
    logic [CLUSTER_W-1:0] first;
    logic [SIZE_W-1:0]    flen;
    logic [SIZE_W-1:0]    dlim;
  } walk_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [CYL_W-1:0]       cyl;
    logic                   head;
    logic [SECTOR_W-1:0]    sec;
    logic [CHUNK_OUT_W-1:0] chunk;
    logic [SIZE_W-1:0]      offset;
    logic                   last;
  } walk_result_t;

  // Tracks table contents and walk state, queues expected result words
  class chain_scoreboard;
    bit [7:0]     fat [FAT_SIZE];
    bit           written [FAT_SIZE];
    bit [11:0]    cluster;
    bit [23:0]    done;
    bit [23:0]    total;
    bit           active;
    bit [15:0]    das;
    bit [7:0]     spc;
    walk_result_t expected_q[$];
    int           errors;

    function new();
      das = 16'd33;
      spc = 8'd1;
    endfunction

    function bit [7:0] table_rd(int unsigned idx);
      return (idx < FAT_SIZE) ? fat[idx] : 8'h00;
    endfunction

    function bit chained(bit [11:0] c);
      return (c >= CHAIN_LO) && (c <= CHAIN_HI);
    endfunction

    // Packed 12-bit entry of cluster c
    function bit [11:0] entry_of(bit [11:0] c);
      int unsigned off;
      bit [15:0]   v;
      off = int'(c) + (int'(c) >> 1);
      v = {table_rd(off + 1), table_rd(off)};
      return c[0] ? v[15:4] : v[11:0];
    endfunction

    // Next word of op NEXT would issue a sector and read the table
    function bit walk_busy();
      return active && chained(cluster) && (done < total);
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DATA_AREA_START) das = data;
      else if (idx == REG_SECTORS_PER_CLUSTER) spc = data[7:0];
    endfunction

    function void note(walk_item_t it);
      walk_result_t r;
      int unsigned  lba, remain, chunk;
      r = '0;
      case (it.op)
        OP_WRITE: begin
          fat[it.tindex] = it.tbyte;
          written[it.tindex] = 1'b1;
          r.status = STAT_STORED;
        end
        OP_START: begin
          if (it.first == 0) begin
            active = 1'b0;
            r.status = STAT_NOT_FOUND;
          end else if (it.flen > it.dlim) begin
            active = 1'b0;
            r.status = STAT_TOO_LARGE;
          end else begin
            cluster = it.first;
            done = '0;
            total = it.flen;
            active = 1'b1;
            r.status = STAT_STARTED;
          end
        end
        OP_NEXT: begin
          if (!walk_busy()) begin
            active = 1'b0;
            r.status = STAT_COMPLETE;
          end else begin
            lba = int'(das) + (int'(cluster) - int'(CHAIN_LO)) * int'(spc);
            remain = total - done;
            chunk = (remain < SECTOR_SIZE) ? remain : SECTOR_SIZE;
            r.status = STAT_SECTOR;
            r.cyl = 8'((lba / CYL_SECTORS) & 32'hFF);
            r.head = 1'((lba / TRACK_SECTORS) & 32'h1);
            r.sec = 5'((lba % TRACK_SECTORS) + 1);
            r.chunk = 10'(chunk);
            r.offset = done;
            done = 24'(int'(done) + chunk);
            cluster = entry_of(cluster);
            r.last = (done >= total) || !chained(cluster);
            if (r.last) active = 1'b0;
          end
        end
        default: return;  // unused code, no result word
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check(walk_result_t got);
      walk_result_t want;
      string        bad;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with no expectation, status %0d", got.status));
        return;
      end
      want = expected_q.pop_front();
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.cyl !== want.cyl) bad = {bad, " cylinder"};
      if (got.head !== want.head) bad = {bad, " head"};
      if (got.sec !== want.sec) bad = {bad, " sector"};
      if (got.chunk !== want.chunk) bad = {bad, " chunk"};
      if (got.offset !== want.offset) bad = {bad, " offset"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "")
        report($sformatf({"%s | got st=%0d c=%0d h=%0d s=%0d n=%0d o=%0d l=%0d",
                          " | want st=%0d c=%0d h=%0d s=%0d n=%0d o=%0d l=%0d"},
               bad, got.status, got.cyl, got.head, got.sec, got.chunk, got.offset,
               got.last, want.status, want.cyl, want.head, want.sec, want.chunk,
               want.offset, want.last));
    endtask
  endclass

  logic clk;
  logic rst;

  fccw_item_if   item_bus ();
  fccw_result_if result_bus ();
  fccw_cfg_if    cfg_bus ();

  fat12_cluster_chain_walker_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  chain_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int items_sent    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check accepted words, random stalls, long hold-off on request
  always @(posedge clk) begin : result_sink
    walk_result_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.status = result_bus.status;
      got.cyl    = result_bus.cylinder;
      got.head   = result_bus.head;
      got.sec    = result_bus.sector_number;
      got.chunk  = result_bus.chunk_bytes;
      got.offset = result_bus.dest_offset;
      got.last   = result_bus.last;
      sb.check(got);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Word builders; fields the operation ignores carry random values
  function automatic walk_item_t mk_any(op_t op);
    walk_item_t it;
    it.op     = op;
    it.tindex = INDEX_W'($urandom);
    it.tbyte  = BYTE_W'($urandom);
    it.first  = CLUSTER_W'($urandom);
    it.flen   = SIZE_W'($urandom);
    it.dlim   = SIZE_W'($urandom);
    return it;
  endfunction

  function automatic walk_item_t mk_write(int unsigned idx, int unsigned b);
    walk_item_t it;
    it = mk_any(OP_WRITE);
    it.tindex = idx[INDEX_W-1:0];
    it.tbyte  = b[BYTE_W-1:0];
    return it;
  endfunction

  function automatic walk_item_t mk_start(bit [11:0] c, bit [23:0] fl, bit [23:0] dl);
    walk_item_t it;
    it = mk_any(OP_START);
    it.first = c;
    it.flen  = fl;
    it.dlim  = dl;
    return it;
  endfunction

  // Offer one word, with random idle cycles in front of it
  task automatic send(input walk_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_bus.valid         <= 1'b1;
    item_bus.operation     <= it.op;
    item_bus.table_index   <= it.tindex;
    item_bus.table_byte    <= it.tbyte;
    item_bus.start_cluster <= it.first;
    item_bus.file_length   <= it.flen;
    item_bus.dest_limit    <= it.dlim;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    sb.note(it);
    if (it.op != OP_NONE) items_sent++;
  endtask

  // Write the 12-bit entry of cluster c, keeping the neighbor's nibble
  task automatic set_entry(bit [11:0] c, bit [11:0] v);
    int unsigned off;
    bit [7:0]    lo, hi;
    off = int'(c) + (int'(c) >> 1);
    if (c[0]) begin
      lo = {v[3:0], sb.fat[off][3:0]};
      hi = v[11:4];
    end else begin
      lo = v[7:0];
      hi = {sb.fat[off + 1][7:4], v[11:8]};
    end
    send(mk_write(off, 32'(lo)));
    send(mk_write(off + 1, 32'(hi)));
  endtask

  // Next-sector word; table bytes it would read get written first
  task automatic issue_next();
    int unsigned off;
    if (sb.walk_busy()) begin
      off = int'(sb.cluster) + (int'(sb.cluster) >> 1);
      if (!sb.written[off]) send(mk_write(off, $urandom));
      if (!sb.written[off + 1]) send(mk_write(off + 1, $urandom));
    end
    send(mk_any(OP_NEXT));
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic quiesce();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Well-formed walk: build a chain, start a file on it, step through it
  task automatic chain_walk();
    bit [11:0]   links [6];
    bit [11:0]   end_mark;
    bit [23:0]   flen, dlim;
    int unsigned span;
    int          len;
    len = $urandom_range(1, 6);
    links[0] = 12'($urandom_range(CHAIN_LO, CHAIN_HI));
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(99) < 30 && links[i-1] < CHAIN_HI) links[i] = links[i-1] + 12'd1;
      else links[i] = 12'($urandom_range(CHAIN_LO, CHAIN_HI));
    end
    for (int i = 0; i < len - 1; i++) set_entry(links[i], links[i+1]);
    case ($urandom_range(3))
      0:       end_mark = 12'h000;
      1:       end_mark = 12'h001;
      2:       end_mark = 12'($urandom_range(12'hFF7, 12'hFFF));
      default: end_mark = 12'($urandom_range(CHAIN_LO, CHAIN_HI));  // runs on into the table
    endcase
    set_entry(links[len-1], end_mark);
    span = len * SECTOR_SIZE;
    case ($urandom_range(9))
      0:       flen = '0;
      1:       flen = 24'($urandom);
      2:       flen = 24'(span);
      3, 4:    flen = 24'(span + $urandom_range(1, 1500));
      default: flen = 24'($urandom_range(1, span));
    endcase
    case ($urandom_range(9))
      0:       dlim = 24'($urandom);
      1:       dlim = flen;
      2:       dlim = 24'hFFFFFF;
      3:       dlim = flen - 24'd1;
      default: dlim = 24'(flen + $urandom_range(0, 5000));
    endcase
    send(mk_start(links[0], flen, dlim));
    repeat (len + $urandom_range(0, 2)) issue_next();
  endtask

  // Loose words of any kind
  task automatic noise_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) send(mk_write($urandom, $urandom));
    else if (pick < 60) send(mk_start(12'($urandom), ($urandom_range(3) == 0) ?
                                      24'($urandom_range(0, 2000)) : 24'($urandom),
                                      24'($urandom)));
    else if (pick < 88) issue_next();
    else if (pick < 94) send(mk_any(OP_NONE));
    else send(mk_start(12'h000, 24'($urandom), 24'($urandom)));
  endtask

  task automatic run_segment(int das, int spc, int s_idle, int r_idle, bit hold, bit pause);
    int target, half;
    bit mid_done;
    quiesce();
    cfg_write(REG_DATA_AREA_START, CFG_DATA_W'(das));
    cfg_write(REG_SECTORS_PER_CLUSTER, CFG_DATA_W'(spc));
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = items_sent + SEG_ITEMS;
    half = items_sent + SEG_ITEMS / 2;
    mid_done = 1'b0;
    while (items_sent < target) begin
      if (!mid_done && items_sent >= half) begin
        mid_done = 1'b1;
        if (hold) hold_req++;
        if (pause) quiesce();
      end
      if ($urandom_range(99) < 70) chain_walk();
      else noise_item();
    end
  endtask

  // Extremes and special cases under the reset settings
  task automatic directed();
    send(mk_any(OP_NEXT));                                // next with no walk
    send(mk_start(12'h000, 24'd100, 24'd200));            // cluster zero
    send(mk_start(12'h005, 24'hFFFFFF, 24'hFFFFFE));      // larger than limit
    send(mk_write(FAT_SIZE - 1, 32'hFF));
    send(mk_write(0, 32'h00));
    send(mk_start(CHAIN_LO, 24'd0, 24'd0));               // empty file
    issue_next();
    set_entry(12'h002, 12'h003);
    set_entry(12'h003, 12'hFFF);
    send(mk_start(CHAIN_LO, 24'd700, 24'hFFFFFF));        // two sectors, size ends it
    issue_next();
    issue_next();
    issue_next();
    set_entry(CHAIN_HI, 12'h000);
    send(mk_start(CHAIN_HI, 24'hFFFFFF, 24'hFFFFFF));     // chain end stops it
    issue_next();
    issue_next();
    send(mk_start(12'h001, 24'd10, 24'd10));              // first cluster below chain
    issue_next();
    send(mk_any(OP_NONE));                                // unused code
    send(mk_start(12'hFFF, 24'd10, 24'd10));              // first cluster above chain
    issue_next();
  endtask

  // Stimulus
  initial begin : stimulus
    int drain;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_NONE;
    item_bus.table_index = '0;
    item_bus.table_byte = '0;
    item_bus.start_cluster = '0;
    item_bus.file_length = '0;
    item_bus.dest_limit = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    run_segment(0, 128, 20, 82, 1'b1, 1'b0);
    run_segment(65535, 1, 20, 82, 1'b0, 1'b0);
    run_segment($urandom_range(0, 65535), $urandom_range(1, 128), 82, 20, 1'b0, 1'b1);
    run_segment(65535, 128, 82, 20, 1'b1, 1'b0);
    run_segment($urandom_range(0, 65535), $urandom_range(1, 128), 0, 0, 1'b0, 1'b0);
    run_segment(33, 1, 0, 0, 1'b0, 1'b1);

    // Drain
    item_bus.valid <= 1'b0;
    drain = 0;
    while (sb.expected_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.expected_q.size()));
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fccw_pkg.sv
sv/fccw_intf.sv
sv/fccw_ram.sv
sv/fccw_ctrl.sv
sv/fccw_datapath.sv
sv/fat12_cluster_chain_walker_unit.sv
sv/fccw_checker.sv
test/tb.sv
